FILE: sv/s2c_pkg.sv
// Shared widths, constants and types for the seconds-to-calendar-date converter.
package s2c_pkg;

    // Field widths
    localparam int unsigned SECS_W  = 32;
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;

    // Internal widths
    localparam int unsigned DAYS_W  = 16;  // whole days, < 49711
    localparam int unsigned TOD_W   = 17;  // seconds of day, < 86400
    localparam int unsigned RDAY_W  = 18;  // uncorrected remainder, < 2 * 86400
    localparam int unsigned MOD_W   = 11;  // minute of day, day of cycle
    localparam int unsigned CYC_W   = 6;   // four-year cycle count, < 35
    localparam int unsigned DOY_W   = 9;   // day of year
    localparam int unsigned YIC_W   = 2;   // year within cycle

    // Total register stages from input to output
    localparam int unsigned PIPE_DEPTH = 7;

    // First day of 2100
    localparam logic [SECS_W-1:0] LIMIT_2100 = 32'd4102444800;

    // 86400 = 128 * 675; floor(2^32 / 675) gives a quotient low by at most one
    localparam int unsigned          DAY_PRE_SHIFT = 7;
    localparam int unsigned          X_W           = SECS_W - DAY_PRE_SHIFT;
    localparam logic [22:0]          DAY_RECIP     = 23'd6362914;
    localparam int unsigned          DAY_SHIFT     = 32;
    localparam logic [TOD_W-1:0]     SECS_PER_DAY  = 17'd86400;

    // Exact x / 15 for x < 2^15
    localparam logic [15:0]          DIV15_RECIP   = 16'd34953;
    localparam int unsigned          DIV15_SHIFT   = 19;
    localparam logic [SEC_W-1:0]     SIXTY         = 6'd60;

    // Exact x / 1461 for x < 2^16
    localparam logic [15:0]          CYC_RECIP     = 16'd45934;
    localparam int unsigned          CYC_SHIFT     = 26;
    localparam logic [MOD_W-1:0]     DAYS_PER_CYCLE = 11'd1461;

    localparam logic [YEAR_W-1:0]    BASE_YEAR     = 12'd1970;
    localparam logic [YIC_W-1:0]     LEAP_YIC      = 2'd2;

    typedef logic [MOD_W-1:0] t_cday;
    typedef logic [DOY_W-1:0] t_doy;

    // First day of each year of the cycle (1970, 1971, 1972 leap, 1973)
    localparam t_cday YEAR_START [4] = '{11'd0, 11'd365, 11'd730, 11'd1096};

    localparam t_doy MONTH_START_NORM [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };
    localparam t_doy MONTH_START_LEAP [12] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
        9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
    };

    // Day split result handed to the clock and date sections
    typedef struct packed {
        logic              inr;
        logic [DAYS_W-1:0] days;
        logic [TOD_W-1:0]  tod;
    } t_dsplit;

endpackage

FILE: sv/s2c_if.sv
// Valid/ready channel interfaces for the converter's input and result items.
interface s2c_in_if;
    import s2c_pkg::*;
    logic              valid;
    logic              ready;
    logic [SECS_W-1:0] unix_seconds;

    modport source (output valid, output unix_seconds, input ready);
    modport sink   (input valid, input unix_seconds, output ready);
endinterface

interface s2c_out_if;
    import s2c_pkg::*;
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day_of_month;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic               in_range;

    modport source (output valid, output year, output month, output day_of_month,
                    output hour, output minute, output second, output in_range,
                    input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                    input hour, input minute, input second, input in_range,
                    output ready);
endinterface

FILE: sv/s2c_dsplit.sv
// Three-stage split of the seconds count into whole days and seconds of the day.
module s2c_dsplit (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [s2c_pkg::SECS_W-1:0]   i_secs,
    output s2c_pkg::t_dsplit             o_split
);
    import s2c_pkg::*;

    logic [SECS_W-1:0]      r_t1;
    logic                   r_inr1;
    logic [X_W+22:0]        r_p1;
    logic                   r_inr2;
    logic [DAYS_W-1:0]      r_q2;
    logic [RDAY_W-1:0]      r_r2;
    t_dsplit                r_out;

    logic [DAYS_W-1:0]      n_q;
    logic [SECS_W:0]        n_r;
    t_dsplit                n_out;

    always_comb begin
        n_q = r_p1[DAY_SHIFT +: DAYS_W];
        n_r = {1'b0, r_t1} - (SECS_W+1)'(n_q * SECS_PER_DAY);
        // estimate is at most one day low
        n_out.inr = r_inr2;
        if (r_r2 >= RDAY_W'(SECS_PER_DAY)) begin
            n_out.days = r_q2 + DAYS_W'(1);
            n_out.tod  = TOD_W'(r_r2 - RDAY_W'(SECS_PER_DAY));
        end else begin
            n_out.days = r_q2;
            n_out.tod  = TOD_W'(r_r2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1   <= i_secs;
            r_inr1 <= (i_secs < LIMIT_2100);
            r_p1   <= i_secs[SECS_W-1:DAY_PRE_SHIFT] * DAY_RECIP;
            r_inr2 <= r_inr1;
            r_q2   <= n_q;
            r_r2   <= n_r[RDAY_W-1:0];
            r_out  <= n_out;
        end
    end

    assign o_split = r_out;

endmodule

FILE: sv/s2c_clock.sv
// Four-stage hour/minute/second extraction from the seconds of the day.
module s2c_clock (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [s2c_pkg::TOD_W-1:0]    i_tod,
    output logic [s2c_pkg::HOUR_W-1:0]   o_hour,
    output logic [s2c_pkg::MIN_W-1:0]    o_minute,
    output logic [s2c_pkg::SEC_W-1:0]    o_second
);
    import s2c_pkg::*;

    logic [TOD_W-1:0]   r_tod4;
    logic [MOD_W-1:0]   r_mt4;
    logic [MOD_W-1:0]   r_mt5;
    logic [HOUR_W-1:0]  r_hr5;
    logic [SEC_W-1:0]   r_sec5;
    logic [HOUR_W-1:0]  r_hr6;
    logic [MIN_W-1:0]   r_min6;
    logic [SEC_W-1:0]   r_sec6;
    logic [HOUR_W-1:0]  r_hr7;
    logic [MIN_W-1:0]   r_min7;
    logic [SEC_W-1:0]   r_sec7;

    logic [30:0]        n_mt_prod;
    logic [24:0]        n_hr_prod;
    logic [TOD_W-1:0]   n_sec;
    logic [MOD_W-1:0]   n_min;

    always_comb begin
        // minute of day = (tod / 4) / 15
        n_mt_prod = i_tod[TOD_W-1:2] * DIV15_RECIP;
        n_hr_prod = r_mt4[MOD_W-1:2] * DIV15_RECIP;
        n_sec     = r_tod4 - TOD_W'(r_mt4 * SIXTY);
        n_min     = r_mt5 - MOD_W'(r_hr5 * SIXTY);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tod4 <= i_tod;
            r_mt4  <= n_mt_prod[DIV15_SHIFT +: MOD_W];
            r_mt5  <= r_mt4;
            r_hr5  <= n_hr_prod[DIV15_SHIFT +: HOUR_W];
            r_sec5 <= n_sec[SEC_W-1:0];
            r_hr6  <= r_hr5;
            r_min6 <= n_min[MIN_W-1:0];
            r_sec6 <= r_sec5;
            r_hr7  <= r_hr6;
            r_min7 <= r_min6;
            r_sec7 <= r_sec6;
        end
    end

    assign o_hour   = r_hr7;
    assign o_minute = r_min7;
    assign o_second = r_sec7;

endmodule

FILE: sv/s2c_date.sv
// Four-stage year/month/day extraction from the day count.
module s2c_date (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [s2c_pkg::DAYS_W-1:0]   i_days,
    output logic [s2c_pkg::YEAR_W-1:0]   o_year,
    output logic [s2c_pkg::MONTH_W-1:0]  o_month,
    output logic [s2c_pkg::DAY_W-1:0]    o_day
);
    import s2c_pkg::*;

    logic [DAYS_W-1:0]   r_days4;
    logic [CYC_W-1:0]    r_cyc4;
    logic [CYC_W-1:0]    r_cyc5;
    logic [MOD_W-1:0]    r_rem5;
    logic [CYC_W-1:0]    r_cyc6;
    logic [YIC_W-1:0]    r_yic6;
    logic [DOY_W-1:0]    r_doy6;
    logic [YEAR_W-1:0]   r_year7;
    logic [MONTH_W-1:0]  r_month7;
    logic [DAY_W-1:0]    r_day7;

    logic [31:0]         n_cyc_prod;
    logic [DAYS_W-1:0]   n_rem;
    logic [YIC_W-1:0]    n_yic;
    logic [MOD_W-1:0]    n_doy;
    logic [MONTH_W-1:0]  n_midx;
    logic [DOY_W-1:0]    n_mstart;
    logic [DOY_W-1:0]    n_day;
    logic                n_leap;

    always_comb begin
        n_cyc_prod = i_days * CYC_RECIP;
        n_rem      = r_days4 - DAYS_W'(r_cyc4 * DAYS_PER_CYCLE);

        // year within the cycle: count year starts passed
        n_yic = YIC_W'(r_rem5 >= YEAR_START[1]) + YIC_W'(r_rem5 >= YEAR_START[2])
              + YIC_W'(r_rem5 >= YEAR_START[3]);
        n_doy = r_rem5 - YEAR_START[n_yic];

        // month within the year: count month starts passed
        n_leap = (r_yic6 == LEAP_YIC);
        n_midx = '0;
        for (int m = 1; m < 12; m++) begin
            if (r_doy6 >= (n_leap ? MONTH_START_LEAP[m] : MONTH_START_NORM[m]))
                n_midx = n_midx + MONTH_W'(1);
        end
        n_mstart = n_leap ? MONTH_START_LEAP[n_midx] : MONTH_START_NORM[n_midx];
        n_day    = r_doy6 - n_mstart + DOY_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_days4  <= i_days;
            r_cyc4   <= n_cyc_prod[CYC_SHIFT +: CYC_W];
            r_cyc5   <= r_cyc4;
            r_rem5   <= n_rem[MOD_W-1:0];
            r_cyc6   <= r_cyc5;
            r_yic6   <= n_yic;
            r_doy6   <= n_doy[DOY_W-1:0];
            r_year7  <= BASE_YEAR + {r_cyc6, 2'b00} + YEAR_W'(r_yic6);
            r_month7 <= n_midx + MONTH_W'(1);
            r_day7   <= n_day[DAY_W-1:0];
        end
    end

    assign o_year  = r_year7;
    assign o_month = r_month7;
    assign o_day   = r_day7;

endmodule

FILE: sv/seconds_to_calendar_date_top.sv
// Top level of the seconds-to-calendar-date converter.
// Usage:
//   i_in  (sink)   : one item per valid/ready handshake carrying unix_seconds,
//                    whole seconds since 1970-01-01 00:00:00.
//   o_out (source) : one result item per input item, in order: year, month,
//                    day_of_month, hour, minute, second and in_range.
//   Counts at or past 2100-01-01 00:00:00 give in_range = 0 and all date and
//   time fields 0.
// Stages: seven register stages (3 for the day split by reciprocal multiply
//   and correction, 4 for the parallel clock and calendar sections); the
//   first stage loads at the accepting edge.
// Throughput: one item per cycle unless stalled; every stage holds its own item.
// Stalls: the whole pipeline freezes while the last stage holds a result the
//   receiver has not taken; i_in.ready drops in that cycle. Bubbles are not
//   squeezed out during a stall; every item keeps its place, so none is
//   dropped or repeated.
// Reset: i_rst_n low (synchronous) clears all stage valid bits; data
//   registers are not reset. No state survives between items.
module seconds_to_calendar_date_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    s2c_in_if.sink       i_in,
    s2c_out_if.source    o_out
);
    import s2c_pkg::*;

    // stage valid bits, index 0 is the first register stage
    logic [PIPE_DEPTH-1:0] r_vld;
    // in-range flag delayed from the day split output to the output stage
    logic [PIPE_DEPTH-4:0] r_inr;

    logic                  n_adv;
    t_dsplit               w_split;

    logic [YEAR_W-1:0]     w_year;
    logic [MONTH_W-1:0]    w_month;
    logic [DAY_W-1:0]      w_day;
    logic [HOUR_W-1:0]     w_hour;
    logic [MIN_W-1:0]      w_minute;
    logic [SEC_W-1:0]      w_second;
    logic                  w_inr;

    // move when the output is empty or being taken
    assign n_adv      = !r_vld[PIPE_DEPTH-1] || o_out.ready;
    assign i_in.ready = n_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_adv) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_inr <= {r_inr[PIPE_DEPTH-5:0], w_split.inr};
        end
    end

    s2c_dsplit u_dsplit (
        .i_clk   (i_clk),
        .i_en    (n_adv),
        .i_secs  (i_in.unix_seconds),
        .o_split (w_split)
    );

    s2c_clock u_clock (
        .i_clk    (i_clk),
        .i_en     (n_adv),
        .i_tod    (w_split.tod),
        .o_hour   (w_hour),
        .o_minute (w_minute),
        .o_second (w_second)
    );

    s2c_date u_date (
        .i_clk   (i_clk),
        .i_en    (n_adv),
        .i_days  (w_split.days),
        .o_year  (w_year),
        .o_month (w_month),
        .o_day   (w_day)
    );

    assign w_inr = r_inr[PIPE_DEPTH-4];

    // out-of-range results read as all zero
    assign o_out.valid        = r_vld[PIPE_DEPTH-1];
    assign o_out.in_range     = w_inr;
    assign o_out.year         = w_inr ? w_year   : '0;
    assign o_out.month        = w_inr ? w_month  : '0;
    assign o_out.day_of_month = w_inr ? w_day    : '0;
    assign o_out.hour         = w_inr ? w_hour   : '0;
    assign o_out.minute       = w_inr ? w_minute : '0;
    assign o_out.second       = w_inr ? w_second : '0;

endmodule

FILE: bench/s2c_check_pkg.sv
// Calendar predictor and result scoreboard for the seconds-to-calendar-date bench.
package s2c_check_pkg;
    import s2c_pkg::*;

    localparam int unsigned           SECS_IN_MINUTE   = 60;
    localparam int unsigned           SECS_IN_HOUR     = 3600;
    localparam int unsigned           SECS_IN_DAY      = 86400;
    localparam int unsigned           DAYS_IN_CYCLE    = 1461;
    localparam int unsigned           YEARS_IN_CYCLE   = 4;
    localparam int unsigned           MONTHS_IN_YEAR   = 12;
    localparam int unsigned           MONTHS_IN_CYCLE  = 48;
    localparam int unsigned           LEAP_YEAR_SLOT   = 2;   // 1972, 1976, ...
    localparam int unsigned           FEB_SLOT         = 1;
    localparam int unsigned           FEBRUARY         = 2;
    localparam int unsigned           LEAP_DAY         = 29;
    localparam int unsigned           EPOCH_YEAR       = 1970;
    localparam int unsigned           DAYS_BEFORE_2100 = 47482;
    localparam logic [SECS_W-1:0]     FIRST_SEC_2100   = 32'd4102444800;
    localparam int unsigned           MONTH_DAYS [12]  = '{31, 28, 31, 30, 31, 30,
                                                           31, 31, 30, 31, 30, 31};
    localparam int unsigned           MAX_PRINTED      = 30;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day_of_month;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
        logic               in_range;
    } cal_fields_t;

    typedef struct {
        logic [SECS_W-1:0] secs;
        cal_fields_t       date;
    } pending_date_t;

    class calendar_scoreboard;
        pending_date_t pending_dates_q[$];
        int unsigned   n_accepted;
        int unsigned   n_checked;
        int unsigned   n_past_2099;
        int unsigned   n_leap_days;
        int unsigned   n_errors;

        // Day count split into a 4-year cycle, then month lengths walked.
        function cal_fields_t unix_to_calendar(logic [SECS_W-1:0] secs);
            cal_fields_t d;
            int unsigned day_count, sec_of_day, cycle_no, day_left, mon_idx, mlen;
            d = '0;
            if (secs >= FIRST_SEC_2100)
                return d;
            day_count  = secs / SECS_IN_DAY;
            sec_of_day = secs % SECS_IN_DAY;
            cycle_no   = day_count / DAYS_IN_CYCLE;
            day_left   = day_count % DAYS_IN_CYCLE;
            mon_idx    = 0;
            while (mon_idx < MONTHS_IN_CYCLE) begin
                mlen = MONTH_DAYS[mon_idx % MONTHS_IN_YEAR];
                if (mon_idx == LEAP_YEAR_SLOT * MONTHS_IN_YEAR + FEB_SLOT)
                    mlen = mlen + 1;
                if (day_left < mlen)
                    break;
                day_left -= mlen;
                mon_idx++;
            end
            d.year         = YEAR_W'(EPOCH_YEAR + cycle_no * YEARS_IN_CYCLE
                                     + mon_idx / MONTHS_IN_YEAR);
            d.month        = MONTH_W'(mon_idx % MONTHS_IN_YEAR + 1);
            d.day_of_month = DAY_W'(day_left + 1);
            d.hour         = HOUR_W'(sec_of_day / SECS_IN_HOUR);
            d.minute       = MIN_W'((sec_of_day % SECS_IN_HOUR) / SECS_IN_MINUTE);
            d.second       = SEC_W'(sec_of_day % SECS_IN_MINUTE);
            d.in_range     = 1'b1;
            return d;
        endfunction

        task note_input(logic [SECS_W-1:0] secs);
            pending_date_t p;
            p.secs = secs;
            p.date = unix_to_calendar(secs);
            pending_dates_q.push_back(p);
            n_accepted++;
        endtask

        task report(string msg);
            n_errors++;
            if (n_errors <= MAX_PRINTED)
                $display("MISMATCH: %s", msg);
        endtask

        task compare_field(logic [SECS_W-1:0] secs, string name,
                           int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("secs %0d %s: got %0d, want %0d", secs, name, got, want));
        endtask

        task check_result(cal_fields_t got);
            pending_date_t p;
            if (pending_dates_q.size() == 0) begin
                report($sformatf("result with nothing pending: %0d-%0d-%0d in_range %0b",
                                 got.year, got.month, got.day_of_month, got.in_range));
                return;
            end
            p = pending_dates_q.pop_front();
            n_checked++;
            if (!p.date.in_range)
                n_past_2099++;
            else if (p.date.month == FEBRUARY && p.date.day_of_month == LEAP_DAY)
                n_leap_days++;
            compare_field(p.secs, "year",         got.year,         p.date.year);
            compare_field(p.secs, "month",        got.month,        p.date.month);
            compare_field(p.secs, "day_of_month", got.day_of_month, p.date.day_of_month);
            compare_field(p.secs, "hour",         got.hour,         p.date.hour);
            compare_field(p.secs, "minute",       got.minute,       p.date.minute);
            compare_field(p.secs, "second",       got.second,       p.date.second);
            compare_field(p.secs, "in_range",     got.in_range,     p.date.in_range);
        endtask
    endclass

endpackage

FILE: bench/seconds_to_calendar_date_top_tb.sv
// Self-checking bench for seconds_to_calendar_date_top with random idling on both channels.
module seconds_to_calendar_date_top_tb;
    import s2c_pkg::*;
    import s2c_check_pkg::*;

    // Run shape
    localparam int unsigned N_RANDOM     = 1875;
    localparam int unsigned RESET_CYCLES = 10;
    localparam int unsigned DRAIN_CYCLES = 4 * PIPE_DEPTH;
    localparam int unsigned HOLD_CYCLES  = 300;     // long receiver hold-off
    localparam int unsigned HOLD_FIRST   = 400;     // cycle counts after reset
    localparam int unsigned HOLD_SECOND  = 3500;
    localparam int unsigned FREE_PHASE   = 3;       // phase of 4 with no idling
    localparam longint      RUN_LIMIT    = 64'd20_000_000;

    // Hand-picked counts: epoch, clock rollovers, the leap day of 1972 and of
    // 2096, the end of the leap year, a cycle boundary, the signed 32-bit
    // rollover, alternating bit patterns, the last second before 2100, the
    // first seconds of 2100 and the all-ones count.
    localparam logic [SECS_W-1:0] EDGE_SECS [25] = '{
        32'd0,          32'd1,          32'd59,         32'd60,
        32'd3599,       32'd3600,       32'd86399,      32'd86400,
        32'd68169599,   32'd68169600,   32'd68255999,   32'd68256000,
        32'd94694399,   32'd94694400,   32'd126230399,  32'd126230400,
        32'd2147483647, 32'd2147483648, 32'd3981357296, 32'hAAAAAAAA,
        32'h55555555,   32'd4102444799, 32'd4102444800, 32'd4102444801,
        32'hFFFFFFFF
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    s2c_in_if  u_in_if ();
    s2c_out_if u_out_if ();

    seconds_to_calendar_date_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in_if),
        .o_out   (u_out_if)
    );

    calendar_scoreboard date_board = new();
    int unsigned        input_stall_cycles = 0;

    always #10 i_clk = ~i_clk;

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Random counts: mostly plain dates, some landing on day edges with
    // clock edges inside the day, and some at or past 2100.
    function automatic logic [SECS_W-1:0] random_secs();
        int unsigned r, day_no, tod;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(FIRST_SEC_2100 - 1, 0);
        if (r < 85) begin
            day_no = $urandom_range(DAYS_BEFORE_2100 - 1, 0);
            case ($urandom_range(4))
                0:       tod = 0;
                1:       tod = SECS_IN_MINUTE - 1;
                2:       tod = SECS_IN_HOUR - 1;
                3:       tod = SECS_IN_DAY - 1;
                default: tod = $urandom_range(SECS_IN_DAY - 1, 0);
            endcase
            return day_no * SECS_IN_DAY + tod;
        end
        if (r < 95)
            return $urandom_range(32'hFFFFFFFF, FIRST_SEC_2100);
        return $urandom();
    endfunction

    // Offer one item after a gap; returns once the block has taken it.
    // valid is written once per falling edge, so back-to-back items keep it high.
    task automatic send_secs(input logic [SECS_W-1:0] secs, input int unsigned gap);
        repeat (gap) begin
            @(negedge i_clk);
            u_in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        u_in_if.valid        <= 1'b1;
        u_in_if.unix_seconds <= secs;
        do @(posedge i_clk); while (!u_in_if.ready);
    endtask

    // Observe both channels at the rising edge; items count only on valid && ready.
    always @(posedge i_clk) begin
        cal_fields_t got;
        if (i_rst_n) begin
            if (u_in_if.valid && u_in_if.ready)
                date_board.note_input(u_in_if.unix_seconds);
            if (u_in_if.valid && !u_in_if.ready)
                input_stall_cycles++;
            if (u_out_if.valid && u_out_if.ready) begin
                got.year         = u_out_if.year;
                got.month        = u_out_if.month;
                got.day_of_month = u_out_if.day_of_month;
                got.hour         = u_out_if.hour;
                got.minute       = u_out_if.minute;
                got.second       = u_out_if.second;
                got.in_range     = u_out_if.in_range;
                date_board.check_result(got);
            end
        end
    end

    // Receiver: random stalls, a stretch with none every fourth phase, and two
    // long hold-offs that let the pipeline fill and push back on the sender.
    initial begin : result_sink
        int unsigned cyc, stall, holds_done;
        u_out_if.ready = 1'b0;
        cyc            = 0;
        holds_done     = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            cyc++;
            if ((holds_done == 0 && cyc >= HOLD_FIRST)
                || (holds_done == 1 && cyc >= HOLD_SECOND)) begin
                holds_done++;
                u_out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) begin
                    @(negedge i_clk);
                    cyc++;
                end
            end else if ((cyc / 700) % 4 == FREE_PHASE || $urandom_range(99) < 70) begin
                u_out_if.ready <= 1'b1;
            end else begin
                stall = pick_gap() + 1;
                u_out_if.ready <= 1'b0;
                repeat (stall - 1) begin
                    @(negedge i_clk);
                    cyc++;
                end
            end
        end
    end

    // Sender: directed counts first, then the random stream.
    initial begin : stimulus
        int unsigned i;
        u_in_if.valid        = 1'b0;
        u_in_if.unix_seconds = '0;
        i_rst_n              = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (EDGE_SECS[k])
            send_secs(EDGE_SECS[k], (k % 3 == 0) ? pick_gap() : 0);

        // Every fourth stretch of 250 items goes back to back.
        for (i = 0; i < N_RANDOM; i++)
            send_secs(random_secs(), ((i / 250) % 4 == 2) ? 0 : pick_gap());

        @(negedge i_clk);
        u_in_if.valid <= 1'b0;

        // Wait for the pipeline to drain, then a few more periods to catch
        // any stray result.
        while (date_board.pending_dates_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d counts: %0d past 2099, %0d on a leap day.",
                 date_board.n_checked, date_board.n_past_2099, date_board.n_leap_days);
        $display("Input held off for %0d cycles; %0d mismatches.",
                 input_stall_cycles, date_board.n_errors);
        if (date_board.n_errors == 0 && date_board.pending_dates_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin : watchdog
        #(RUN_LIMIT);
        $display("Timed out with %0d results outstanding.",
                 date_board.pending_dates_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
